// ===== design/gradient_amplitude_limiter_macros.svh =====
// Assertion macros for the gradient amplitude limiter; gal_ctrl uses them.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef GRADIENT_AMPLITUDE_LIMITER_MACROS_SVH
`define GRADIENT_AMPLITUDE_LIMITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gal_pkg.sv =====
// Shared constants and controller/datapath interface types for the limiter.
// No dependencies.
`timescale 1ns / 1ps

package gal_pkg;

  localparam int AXES_HW          = 3;
  localparam int LIMIT_W          = 23;
  localparam int FRAC_W           = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 23;
  localparam int DEF_MAX_AXES     = 3;
  localparam int DEF_SAMPLE_WIDTH = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PER_AXIS_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUSHION_FRAC  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_AXES      = 2'd3;

  localparam logic [LIMIT_W-1:0] AMP_LIMIT_RESET = 23'h7FFFFF;
  localparam logic [1:0]         NUM_AXES_RESET  = 2'd3;

  typedef struct packed {
    logic capture;
    logic load_sq;
    logic load_sum;
    logic sqrt_init;
    logic sqrt_step;
    logic load_div;
    logic div_step;
    logic write_out;
  } gal_cmd_t;

  typedef struct packed {
    logic need_div;
  } gal_stat_t;

endpackage

// ===== design/gradient_amplitude_limiter.sv =====
// An item is captured, squared, summed and checked, then written out in per-axis
// mode or when the point is within the shrunk limit; when the norm must be scaled,
// the bit-serial square root and then the per-axis restoring dividers run first.
// One item is in work at a time; the finished result sits in an output register
// while the next item is accepted. Top level; depends on gal_pkg, gal_ctrl
// and gal_dp.
`timescale 1ns / 1ps

module gradient_amplitude_limiter #(
  parameter int MAX_AXES     = gal_pkg::DEF_MAX_AXES,
  parameter int SAMPLE_WIDTH = gal_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // axis0_value, axis1_value, axis2_value, axis0_set_value, axis1_set_value,
  // axis2_set_value
  input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
  // axis0_pinned, axis1_pinned, axis2_pinned
  input  logic [2:0]                            s_tuser,
  input  logic                                  s_tlast,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // axis0_projected, axis1_projected, axis2_projected
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
  // point_ok, waveform_ok
  output logic [1:0]                            m_tuser,
  output logic                                  m_tlast,
  input  logic                                  cfg_we,
  input  logic [gal_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gal_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import gal_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int OUT_W = ((3*SAMPLE_WIDTH+7)/8)*8;

  gal_cmd_t      cmd;
  gal_stat_t     stat;
  logic [SW-1:0] in_value [AXES_HW];
  logic          in_pinned [AXES_HW];
  logic [SW-1:0] in_set [AXES_HW];
  logic [SW-1:0] out_proj [AXES_HW];

  for (genvar i = 0; i < AXES_HW; i++) begin : g_unpack
    assign in_value[i]  = s_tdata[i*SW +: SW];
    assign in_set[i]    = s_tdata[(AXES_HW+i)*SW +: SW];
    assign in_pinned[i] = s_tuser[i];
  end

  assign m_tdata = OUT_W'({out_proj[2], out_proj[1], out_proj[0]});

  gal_ctrl #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  gal_dp #(
    .MAX_AXES     (MAX_AXES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_value  (in_value),
    .in_pinned (in_pinned),
    .in_set    (in_set),
    .in_last   (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_proj  (out_proj),
    .out_ok    (m_tuser[0]),
    .out_wok   (m_tuser[1]),
    .out_last  (m_tlast)
  );

endmodule

// ===== design/gal_ctrl.sv =====
// Sequencing state machine for the limiter.
// Depends on gal_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gradient_amplitude_limiter_macros.svh"

module gal_ctrl #(
  parameter int SAMPLE_WIDTH = gal_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output gal_pkg::gal_cmd_t cmd,
  input  gal_pkg::gal_stat_t stat
);
  import gal_pkg::*;

  localparam int MAX_STEPS = (SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W;
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SAMPLE_WIDTH - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(LIMIT_W - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid, out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.load_sq = 1'b1;
        state_next  = ST_SUM;
      end
      ST_SUM: begin
        cmd.load_sum = 1'b1;
        state_next   = ST_CHK;
      end
      ST_CHK: begin
        cmd.sqrt_init = 1'b1;
        if (stat.need_div) begin
          state_next = ST_SQRT;
          cnt_next   = SQRT_LAST;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_MUL;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_MUL: begin
        cmd.load_div = 1'b1;
        cnt_next     = DIV_LAST;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_FIN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid || m_tready) begin
          cmd.write_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.write_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  `GAL_ASSERT_NEXT(a_write_shows_result, cmd.write_out, m_tvalid, "result not presented after write")
  `GAL_ASSERT_NEXT(a_accept_starts_work, s_tvalid && s_tready, state == ST_SQ, "accepted transaction not started")
  `GAL_ASSERT_NEXT(a_sqrt_ends, state == ST_SQRT && cnt == '0, state == ST_MUL, "square root did not end on time")
  `GAL_ASSERT_NOW(a_div_only_when_needed, state == ST_SQRT || state == ST_MUL || state == ST_DIV, stat.need_div, "norm scaling run without an exceeded limit")

endmodule

// ===== design/gal_dp.sv =====
// Datapath of the limiter: configuration, squares, square root, dividers, output.
// Depends on gal_pkg; driven by gal_ctrl through gal_cmd_t.
`timescale 1ns / 1ps

module gal_dp #(
  parameter int MAX_AXES     = gal_pkg::DEF_MAX_AXES,
  parameter int SAMPLE_WIDTH = gal_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gal_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gal_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [SAMPLE_WIDTH-1:0]          in_value [gal_pkg::AXES_HW],
  input  logic                             in_pinned [gal_pkg::AXES_HW],
  input  logic [SAMPLE_WIDTH-1:0]          in_set [gal_pkg::AXES_HW],
  input  logic                             in_last,
  input  gal_pkg::gal_cmd_t                cmd,
  output gal_pkg::gal_stat_t               stat,
  output logic [SAMPLE_WIDTH-1:0]          out_proj [gal_pkg::AXES_HW],
  output logic                             out_ok,
  output logic                             out_wok,
  output logic                             out_last
);
  import gal_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int SQW   = 2 * SW;
  localparam int LSQW  = 2 * LIMIT_W;
  localparam int CMPW  = (SQW > LSQW) ? SQW : LSQW;
  localparam int CW    = ((SW > LIMIT_W) ? SW : LIMIT_W) + 2;
  localparam int NUMW  = SW + LIMIT_W;
  localparam int TPW   = LIMIT_W + FRAC_W + 1;
  localparam logic [FRAC_W:0] FRAC_ONE = (FRAC_W + 1)'(1) << FRAC_W;

  logic               per_axis_mode;
  logic [LIMIT_W-1:0] amp_limit;
  logic [FRAC_W-1:0]  cushion_frac;
  logic [1:0]         num_axes;
  logic [1:0]         n_act;

  logic [SW-1:0]      x_r   [MAX_AXES];
  logic               pin_r [MAX_AXES];
  logic [SW-1:0]      set_r [MAX_AXES];
  logic               last_r;
  logic [SW-1:0]      mag   [MAX_AXES];
  logic [SQW-1:0]     sq_r  [MAX_AXES];
  logic [SW-1:0]      rem_r [MAX_AXES];
  logic [LIMIT_W-1:0] low_r [MAX_AXES];
  logic [SW-1:0]      val   [MAX_AXES];
  logic               fail  [MAX_AXES];

  logic [TPW-1:0]     tol_prod;
  logic [LIMIT_W-1:0] tol_r;
  logic [LSQW-1:0]    limsq_r, tolsq_r;
  logic [SQW-1:0]     sum_all, sumsq_r;
  logic [SQW-1:0]     sq_n, sq_res, sq_bit, sq_try;
  logic [SW-1:0]      root;
  logic               over, norm_fail, any_fail, ok, wok, accum;
  logic signed [CW-1:0] tpos, lpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      per_axis_mode <= 1'b0;
      amp_limit     <= AMP_LIMIT_RESET;
      cushion_frac  <= '0;
      num_axes      <= NUM_AXES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PER_AXIS_MODE: per_axis_mode <= cfg_data[0];
        REG_AMP_LIMIT:     amp_limit     <= cfg_data[LIMIT_W-1:0];
        REG_CUSHION_FRAC:  cushion_frac  <= cfg_data[FRAC_W-1:0];
        REG_NUM_AXES:      num_axes      <= cfg_data[1:0];
      endcase
    end
  end

  always_comb begin
    if (num_axes == 2'd0) begin
      n_act = 2'd1;
    end else if (32'(num_axes) > MAX_AXES) begin
      n_act = 2'(MAX_AXES);
    end else begin
      n_act = num_axes;
    end
  end

  assign tol_prod = TPW'(amp_limit) * TPW'(FRAC_ONE - {1'b0, cushion_frac});
  assign tpos     = signed'(CW'(tol_r));
  assign lpos     = signed'(CW'(amp_limit));

  always_comb begin
    sum_all = '0;
    for (int i = 0; i < MAX_AXES; i++) begin
      sum_all = sum_all + sq_r[i];
    end
  end

  assign over      = CMPW'(sumsq_r) > CMPW'(tolsq_r);
  assign norm_fail = CMPW'(sumsq_r) > CMPW'(limsq_r);
  assign stat.need_div = !per_axis_mode && over;

  assign sq_try = sq_res + sq_bit;
  assign root   = sq_res[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      last_r <= in_last;
    end
    if (cmd.load_sq) begin
      tol_r   <= tol_prod[LIMIT_W+FRAC_W-1:FRAC_W];
      limsq_r <= LSQW'(amp_limit) * LSQW'(amp_limit);
    end
    if (cmd.load_sum) begin
      sumsq_r <= sum_all;
      tolsq_r <= LSQW'(tol_r) * LSQW'(tol_r);
    end
    if (cmd.sqrt_init) begin
      sq_n   <= sumsq_r;
      sq_res <= '0;
      sq_bit <= SQW'(1) << (SQW - 2);
    end else if (cmd.sqrt_step) begin
      if (sq_n >= sq_try) begin
        sq_n   <= sq_n - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_lane
    logic               act;
    logic [NUMW-1:0]    num;
    logic [SW:0]        trial, diff;
    logic               ge;
    logic signed [CW-1:0] xs, qs, clampv, normv, res;

    assign act   = 32'(n_act) > g;
    assign mag[g] = x_r[g][SW-1] ? (~x_r[g] + 1'b1) : x_r[g];
    assign num   = NUMW'(mag[g]) * NUMW'(tol_r);
    assign trial = {rem_r[g], low_r[g][LIMIT_W-1]};
    assign diff  = trial - {1'b0, root};
    assign ge    = trial >= {1'b0, root};

    assign xs = CW'(signed'(x_r[g]));
    assign qs = signed'(CW'(low_r[g]));

    always_comb begin
      if (xs < -tpos) begin
        clampv = -tpos;
      end else if (xs > tpos) begin
        clampv = tpos;
      end else begin
        clampv = xs;
      end
      normv = x_r[g][SW-1] ? -qs : qs;
      if (!act) begin
        res = '0;
      end else if (pin_r[g]) begin
        res = CW'(signed'(set_r[g]));
      end else if (per_axis_mode) begin
        res = clampv;
      end else if (over) begin
        res = normv;
      end else begin
        res = xs;
      end
    end

    assign val[g]  = res[SW-1:0];
    assign fail[g] = act && !pin_r[g] && ((xs < -lpos) || (xs > lpos));

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        x_r[g]   <= in_value[g];
        pin_r[g] <= in_pinned[g];
        set_r[g] <= in_set[g];
      end
      if (cmd.load_sq) begin
        sq_r[g] <= act ? SQW'(mag[g]) * SQW'(mag[g]) : '0;
      end
      if (cmd.load_div) begin
        rem_r[g] <= num[NUMW-1:LIMIT_W];
        low_r[g] <= num[LIMIT_W-1:0];
      end else if (cmd.div_step) begin
        rem_r[g] <= ge ? diff[SW-1:0] : trial[SW-1:0];
        low_r[g] <= {low_r[g][LIMIT_W-2:0], ge};
      end
      if (cmd.write_out) begin
        out_proj[g] <= val[g];
      end
    end
  end

  for (genvar g = MAX_AXES; g < AXES_HW; g++) begin : g_unused
    assign out_proj[g] = '0;
  end

  always_comb begin
    any_fail = 1'b0;
    for (int i = 0; i < MAX_AXES; i++) begin
      any_fail = any_fail | fail[i];
    end
  end

  assign ok  = per_axis_mode ? !any_fail : !(norm_fail && !pin_r[0]);
  assign wok = accum && ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= 1'b1;
    end else if (cmd.write_out) begin
      accum <= last_r ? 1'b1 : wok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      out_ok   <= ok;
      out_wok  <= wok;
      out_last <= last_r;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for gradient_amplitude_limiter: directed cases, then random points.
// Predicts projected axes and feasibility flags; depends on gal_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import gal_pkg::*;

  localparam int SW = 24;
  localparam int IN_W = ((6*SW+7)/8)*8;
  localparam int OUT_W = ((3*SW+7)/8)*8;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [SW-1:0] v [3];
    logic [2:0] pin;
    logic signed [SW-1:0] sv [3];
    logic last;
  } point_t;

  typedef struct {
    logic signed [SW-1:0] p [3];
    logic pt_ok;
    logic wf_ok;
    logic last;
  } proj_t;

  typedef struct {
    point_t pt;
    logic has_exp;
    proj_t exp_r;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gradient_amplitude_limiter u_dut (.*);

  always #6 clk = ~clk;

  // Predictor copy of the registers and the running feasibility flag.
  logic mode_q;
  logic [22:0] limit_q;
  logic [15:0] cushion_q;
  logic [1:0] axes_q;
  logic feas_q;

  proj_t projections[$];
  row_t directed[$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  longint cycles = 0;
  bit sender_done = 0;

  function automatic logic [63:0] sqrt_floor(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic proj_t project_point(point_t pt);
    proj_t r;
    int n;
    logic [63:0] tol, lim, sumsq, sq, m, rt, q;
    logic ok, over;
    longint x;
    n = (axes_q == 0) ? 1 : axes_q;
    lim = limit_q;
    tol = (lim * (64'd65536 - cushion_q)) >> 16;
    sumsq = 0;
    ok = 1;
    for (int i = 0; i < 3; i++) r.p[i] = '0;
    for (int i = 0; i < n; i++) begin
      x = pt.v[i];
      m = (x < 0) ? -x : x;
      sq = m * m;
      sumsq = (sumsq > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : sumsq + sq;
    end
    if (mode_q) begin
      for (int i = 0; i < n; i++) begin
        x = pt.v[i];
        if (x < -longint'(tol)) r.p[i] = -longint'(tol);
        else if (x > longint'(tol)) r.p[i] = tol;
        else r.p[i] = x;
        if ((x < -longint'(lim) || x > longint'(lim)) && !pt.pin[i]) ok = 0;
      end
    end else begin
      over = sumsq > tol * tol;
      rt = sqrt_floor(sumsq);
      for (int i = 0; i < n; i++) begin
        x = pt.v[i];
        if (over && rt != 0) begin
          m = (x < 0) ? -x : x;
          q = (m * tol) / rt;
          r.p[i] = (x < 0) ? -longint'(q) : longint'(q);
        end else begin
          r.p[i] = x;
        end
      end
      if (sumsq > lim * lim && !pt.pin[0]) ok = 0;
    end
    for (int i = 0; i < n; i++) if (pt.pin[i]) r.p[i] = pt.sv[i];
    feas_q = feas_q & ok;
    r.pt_ok = ok;
    r.wf_ok = feas_q;
    r.last = pt.last;
    if (pt.last) feas_q = 1;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_PER_AXIS_MODE: mode_q = val[0];
      REG_AMP_LIMIT: limit_q = val[22:0];
      REG_CUSHION_FRAC: cushion_q = val[15:0];
      default: axes_q = val[1:0];
    endcase
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) s_tvalid <= 0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_point(point_t pt, logic has_exp, proj_t exp_r);
    proj_t pred;
    s_tvalid <= 1;
    s_tdata <= {pt.sv[2], pt.sv[1], pt.sv[0], pt.v[2], pt.v[1], pt.v[0]};
    s_tuser <= pt.pin;
    s_tlast <= pt.last;
    do @(posedge clk); while (!s_tready);
    pred = project_point(pt);
    if (has_exp && (pred.p != exp_r.p || pred.pt_ok != exp_r.pt_ok
        || pred.wf_ok != exp_r.wf_ok || pred.last != exp_r.last))
      $display("%0t note: table row differs from prediction", $realtime);
    if (has_exp) projections = {projections, exp_r};
    else projections = {projections, pred};
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (projections.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 4095) - 2048;
      2: return ($urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000);
      default: return $urandom_range(0, 2000000) - 1000000;
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t pt;
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      pt.v[i] = rand_sample(style);
      pt.sv[i] = $urandom;
    end
    pt.pin = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000;
    pt.last = ($urandom_range(0, 7) == 0);
    return pt;
  endfunction

  function automatic row_t mk_row(int a, int b, int c, logic [2:0] pin, logic last,
                                  logic has_exp, int e0, int e1, int e2,
                                  logic pok, logic wok);
    row_t r;
    r.pt.v[0] = a; r.pt.v[1] = b; r.pt.v[2] = c;
    r.pt.sv[0] = 24'sh123456; r.pt.sv[1] = -24'sd77; r.pt.sv[2] = 24'sh7FFFFF;
    r.pt.pin = pin;
    r.pt.last = last;
    r.has_exp = has_exp;
    r.exp_r.p[0] = e0; r.exp_r.p[1] = e1; r.exp_r.p[2] = e2;
    r.exp_r.pt_ok = pok;
    r.exp_r.wf_ok = wok;
    r.exp_r.last = last;
    return r;
  endfunction

  // Result side: random backpressure and field-by-field comparison.
  always @(posedge clk) begin
    proj_t e;
    logic signed [SW-1:0] a [3];
    if (!rst) begin
      cycles <= cycles + 1;
      if (m_tvalid && m_tready) begin
        a[0] = m_tdata[SW-1:0];
        a[1] = m_tdata[2*SW-1:SW];
        a[2] = m_tdata[3*SW-1:2*SW];
        if (projections.size() == 0) begin
          $display("%0t unexpected transaction: data %h user %b", $realtime, m_tdata, m_tuser);
          errors++;
        end else begin
          e = projections.pop_front();
          got++;
          for (int i = 0; i < 3; i++)
            if (a[i] !== e.p[i]) begin
              $display("%0t axis%0d projected: expected %0d actual %0d", $realtime, i,
                       e.p[i], a[i]);
              errors++;
            end
          if (m_tuser[0] !== e.pt_ok) begin
            $display("%0t point_ok: expected %b actual %b", $realtime, e.pt_ok, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== e.wf_ok) begin
            $display("%0t waveform_ok: expected %b actual %b", $realtime, e.wf_ok, m_tuser[1]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $display("%0t final_out: expected %b actual %b", $realtime, e.last, m_tlast);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 99) < 3) m_tready <= 0;
      else if (!m_tready && $urandom_range(0, 99) < 25) m_tready <= 1;
      else if (m_tready && $urandom_range(0, 99) < 15) m_tready <= 0;
      else if (!m_tready && sender_done) m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    proj_t none;
    mode_q = 0;
    limit_q = AMP_LIMIT_RESET;
    cushion_q = 0;
    axes_q = NUM_AXES_RESET;
    feas_q = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset settings: full limit, norm mode, three axes.
    directed = {directed, mk_row(0, 0, 0, 3'b000, 0, 1, 0, 0, 0, 1, 1)};
    directed = {directed, mk_row(100, -200, 300, 3'b000, 0, 1, 100, -200, 300, 1, 1)};
    directed = {directed, mk_row(8388607, 0, 0, 3'b000, 0, 1, 8388607, 0, 0, 1, 1)};
    directed = {directed, mk_row(-8388608, 0, 0, 3'b000, 1, 0, 0, 0, 0, 0, 0)};
    directed = {directed, mk_row(8388607, 8388607, -8388608, 3'b000, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, mk_row(8388607, 8388607, 8388607, 3'b001, 1, 0, 0, 0, 0, 0, 0)};
    directed = {directed,
                mk_row(5, 6, 7, 3'b111, 1, 1, 24'sh123456, -77, 24'sh7FFFFF, 1, 1)};
    foreach (directed[i]) begin
      idle_gap();
      send_point(directed[i].pt, directed[i].has_exp, directed[i].exp_r);
    end
    drain();

    // Per-axis clamping with a cushion, two axes; third axis must read zero.
    write_reg(REG_PER_AXIS_MODE, 1);
    write_reg(REG_AMP_LIMIT, 1000);
    write_reg(REG_CUSHION_FRAC, 32768);
    write_reg(REG_NUM_AXES, 2);
    send_point(mk_row(2000, -2000, 9, 3'b000, 0, 1, 500, -500, 0, 0, 0).pt, 1,
               mk_row(2000, -2000, 9, 3'b000, 0, 1, 500, -500, 0, 0, 0).exp_r);
    send_point(mk_row(400, -1000, 9, 3'b100, 1, 1, 400, -500, 0, 1, 0).pt, 1,
               mk_row(400, -1000, 9, 3'b100, 1, 1, 400, -500, 0, 1, 0).exp_r);
    send_point(mk_row(-5000, 1, 1, 3'b001, 1, 0, 0, 0, 0, 0, 0).pt, 0, none);
    drain();

    // Zero limit, axis count zero taken as one, largest cushion.
    write_reg(REG_PER_AXIS_MODE, 0);
    write_reg(REG_AMP_LIMIT, 0);
    write_reg(REG_NUM_AXES, 0);
    write_reg(REG_CUSHION_FRAC, 65535);
    send_point(mk_row(-3, 4, 5, 3'b000, 1, 1, 0, 0, 0, 0, 0).pt, 1,
               mk_row(-3, 4, 5, 3'b000, 1, 1, 0, 0, 0, 0, 0).exp_r);
    send_point(mk_row(0, 4, 5, 3'b000, 1, 1, 0, 0, 0, 1, 1).pt, 1,
               mk_row(0, 4, 5, 3'b000, 1, 1, 0, 0, 0, 1, 1).exp_r);
    drain();

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_PER_AXIS_MODE, $urandom_range(0, 1));
      write_reg(REG_AMP_LIMIT, (ph == 0) ? 23'h7FFFFF : (ph == 1) ? 23'd0 :
                ($urandom_range(0, 1) ? $urandom_range(0, 8388607) : $urandom_range(0, 3000)));
      write_reg(REG_CUSHION_FRAC, (ph == 2) ? 16'hFFFF : $urandom_range(0, 65535));
      write_reg(REG_NUM_AXES, $urandom_range(0, 3));
      for (int k = 0; k < 100; k++) begin
        idle_gap();
        send_point(rand_point(), 0, none);
      end
      drain();
    end

    sender_done = 1;
    drain();
    $display("Covered %0d points (%0d results) over directed extremes and ten random", sent, got);
    $display("register settings in both limiting modes with random pinning and stalls.");
    if (errors == 0 && projections.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
